/* design/bfq_pkg.sv */
`timescale 1ns / 1ps
// package: types, codes and constants for the bounded frame queue
package bfq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int CAP_W = 5;
  localparam int CFG_W = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;
  localparam logic [8:0] AUDIO_FRAME_MS = 9'd20;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_CAPACITY = 1'd0;
  localparam cfg_idx_t CFG_DROP_OLDEST = 1'd1;

  typedef logic [2:0] kind_t;
  localparam kind_t KIND_PUSH = 3'd0;
  localparam kind_t KIND_POP = 3'd1;
  localparam kind_t KIND_PEEK = 3'd2;
  localparam kind_t KIND_FLUSH = 3'd3;
  localparam kind_t KIND_CLOSE = 3'd4;

  typedef logic [1:0] status_t;
  localparam status_t STAT_DONE = 2'd0;
  localparam status_t STAT_FULL = 2'd1;
  localparam status_t STAT_CLOSED = 2'd2;
  localparam status_t STAT_EMPTY = 2'd3;

  typedef logic [1:0] media_t;
  localparam media_t MEDIA_AUDIO = 2'd0;
  localparam media_t MEDIA_VIDEO = 2'd1;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] pts_ms;
    media_t      media_type;
    logic        key_frame;
    logic [31:0] payload_tag;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic        frame_valid;
    logic [31:0] out_pts_ms;
    media_t      out_media_type;
    logic        out_key_frame;
    logic [31:0] out_payload_tag;
    logic [4:0]  queue_size;
    logic [8:0]  audio_duration_ms;
    logic [4:0]  video_frames;
    logic [4:0]  video_key_frames;
  } res_item_t;

  typedef struct packed {
    logic    capture;
    logic    exec;
    logic    write_tail;
    logic    remove_head;
    logic    emit;
    logic    flush;
    logic    close;
    status_t status;
  } dp_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  closed;
    logic  full;
    logic  empty;
    logic  drop_mode;
  } dp_flags_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } ctrl_state_t;

endpackage

/* design/bfq_ram.sv */
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module bfq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/bfq_ctrl.sv */
`timescale 1ns / 1ps
// controller: operation sequencing and decode of the queue commands
module bfq_ctrl
  import bfq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  dp_flags_t flags,
  output dp_cmd_t   cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.status = STAT_DONE;
    busy = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd.capture = start;
      end
      ST_EXEC: begin
        busy = 1'b1;
        cmd.exec = 1'b1;
        unique case (flags.kind)
          KIND_PUSH: begin
            if (flags.closed) begin
              cmd.status = STAT_CLOSED;
            end else if (flags.full && !flags.drop_mode) begin
              cmd.status = STAT_FULL;
            end else begin
              cmd.write_tail = 1'b1;
              // evict the head to make room
              if (flags.full && !flags.empty) begin
                cmd.emit = 1'b1;
                cmd.remove_head = 1'b1;
              end
            end
          end
          KIND_POP, KIND_PEEK: begin
            if (flags.empty) begin
              cmd.status = STAT_EMPTY;
            end else begin
              cmd.emit = 1'b1;
              cmd.remove_head = (flags.kind == KIND_POP);
            end
          end
          KIND_FLUSH: begin
            cmd.flush = 1'b1;
          end
          KIND_CLOSE: begin
            cmd.close = 1'b1;
          end
          default: begin
            cmd.status = STAT_DONE;
          end
        endcase
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

/* design/bfq_dp.sv */
`timescale 1ns / 1ps
// datapath: frame stores, pointers, statistics, configuration and result register
module bfq_dp
  import bfq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  cfg_idx_t             cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  in_item_t             op,
  input  dp_cmd_t              cmd,
  output dp_flags_t            flags,
  output logic                 done,
  output res_item_t            result
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [KW-1:0] DEPTH_K = KW'(DEPTH);

  logic [CAP_W-1:0] capacity;
  logic             drop_mode;
  in_item_t         op_q;

  logic [AW-1:0] head_ptr, head_ptr_next;
  logic [AW-1:0] tail_ptr, tail_ptr_next;
  logic [CW-1:0] frame_count, frame_count_next;
  logic [8:0]    audio_ms_total, audio_ms_total_next;
  logic [4:0]    video_count, video_count_next;
  logic [4:0]    key_count, key_count_next;
  logic          closed_flag;

  logic [31:0] pts_rd;
  logic [34:0] attr_rd;
  logic [34:0] attr_wr;

  logic [KW-1:0] cap_k, cap_eff, count_k;
  logic          rem_audio, rem_video, rem_key;
  logic          add_audio, add_video, add_key;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
      drop_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAPACITY: capacity <= cfg_data;
        CFG_DROP_OLDEST: drop_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q <= op;
    end
  end

  assign attr_wr = {op_q.media_type, op_q.key_frame, op_q.payload_tag};

  bfq_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_pts_store (
    .clk   (clk),
    .we    (cmd.write_tail),
    .waddr (tail_ptr),
    .wdata (op_q.pts_ms),
    .raddr (head_ptr),
    .rdata (pts_rd)
  );

  bfq_ram #(.WIDTH(35), .DEPTH(DEPTH)) u_attr_store (
    .clk   (clk),
    .we    (cmd.write_tail),
    .waddr (tail_ptr),
    .wdata (attr_wr),
    .raddr (head_ptr),
    .rdata (attr_rd)
  );

  // effective capacity clamped to 1..DEPTH
  assign cap_k = KW'(capacity);
  assign count_k = KW'(frame_count);
  always_comb begin
    if (cap_k == '0) begin
      cap_eff = KW'(1);
    end else if (cap_k > DEPTH_K) begin
      cap_eff = DEPTH_K;
    end else begin
      cap_eff = cap_k;
    end
  end

  assign flags.kind = op_q.kind;
  assign flags.closed = closed_flag;
  assign flags.full = (count_k >= cap_eff);
  assign flags.empty = (frame_count == '0);
  assign flags.drop_mode = drop_mode;

  assign rem_audio = cmd.remove_head && (attr_rd[34:33] == MEDIA_AUDIO);
  assign rem_video = cmd.remove_head && (attr_rd[34:33] == MEDIA_VIDEO);
  assign rem_key = rem_video && attr_rd[32];
  assign add_audio = cmd.write_tail && (op_q.media_type == MEDIA_AUDIO);
  assign add_video = cmd.write_tail && (op_q.media_type == MEDIA_VIDEO);
  assign add_key = add_video && op_q.key_frame;

  always_comb begin
    head_ptr_next = head_ptr;
    tail_ptr_next = tail_ptr;
    frame_count_next = frame_count + CW'(cmd.write_tail) - CW'(cmd.remove_head);
    audio_ms_total_next = audio_ms_total + (add_audio ? AUDIO_FRAME_MS : 9'd0)
                          - (rem_audio ? AUDIO_FRAME_MS : 9'd0);
    video_count_next = video_count + 5'(add_video) - 5'(rem_video);
    key_count_next = key_count + 5'(add_key) - 5'(rem_key);
    if (cmd.remove_head) begin
      head_ptr_next = (head_ptr == LAST_SLOT) ? '0 : head_ptr + AW'(1);
    end
    if (cmd.write_tail) begin
      tail_ptr_next = (tail_ptr == LAST_SLOT) ? '0 : tail_ptr + AW'(1);
    end
    if (cmd.flush) begin
      head_ptr_next = '0;
      tail_ptr_next = '0;
      frame_count_next = '0;
      audio_ms_total_next = '0;
      video_count_next = '0;
      key_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr <= '0;
      tail_ptr <= '0;
      frame_count <= '0;
      audio_ms_total <= '0;
      video_count <= '0;
      key_count <= '0;
      closed_flag <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= cmd.exec;
      if (cmd.exec) begin
        head_ptr <= head_ptr_next;
        tail_ptr <= tail_ptr_next;
        frame_count <= frame_count_next;
        audio_ms_total <= audio_ms_total_next;
        video_count <= video_count_next;
        key_count <= key_count_next;
        if (cmd.close) begin
          closed_flag <= 1'b1;
        end
      end
    end
  end

  logic [KW-1:0] count_next_k;
  assign count_next_k = KW'(frame_count_next);

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      result.status <= cmd.status;
      result.frame_valid <= cmd.emit;
      result.out_pts_ms <= cmd.emit ? pts_rd : 32'd0;
      result.out_media_type <= cmd.emit ? attr_rd[34:33] : 2'd0;
      result.out_key_frame <= cmd.emit ? attr_rd[32] : 1'b0;
      result.out_payload_tag <= cmd.emit ? attr_rd[31:0] : 32'd0;
      result.queue_size <= count_next_k[4:0];
      result.audio_duration_ms <= audio_ms_total_next;
      result.video_frames <= video_count_next;
      result.video_key_frames <= key_count_next;
    end
  end

endmodule

/* design/bounded_frame_queue_with_stats.sv */
`timescale 1ns / 1ps
// top level: bounded frame queue with drop-oldest option and buffered-media statistics
//
// operations enter on op (push, pop, peek, flush, close) and transfer at a
// rising edge where start is high and busy is low. busy rises for one cycle
// while the operation executes; the result transfers on result with done high
// for exactly one cycle, registered at the end of the execute cycle. a new
// operation may be started while done is showing. the execute cycle is set by
// the registered read port of the frame stores: the head entry is read at the
// accepting edge and used in the execute cycle.
// capacity and drop-oldest mode have no read-back; the user must write them through
// cfg_we / cfg_index / cfg_data only while no operation is in flight (unenforced).
// every result carries status, the returned frame (zero when frame_valid is
// low) and the frame count, audio time and video counts after the operation.
// reset empties the queue, reopens it, sets capacity to 16 and drop-oldest off;
// frame stores are not cleared and need no clearing pass.
// the receiver cannot stall: done is a strobe and must be taken when shown.
module bounded_frame_queue_with_stats
  import bfq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  in_item_t         op,
  output logic             done,
  output res_item_t        result,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  dp_cmd_t   cmd;
  dp_flags_t flags;

  bfq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .flags (flags),
    .cmd   (cmd)
  );

  bfq_dp #(.DEPTH(DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op        (op),
    .cmd       (cmd),
    .flags     (flags),
    .done      (done),
    .result    (result)
  );

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted operation did not execute");

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without an executed operation");

  a_frame_status: assert property (@(posedge clk) disable iff (rst)
    done && result.frame_valid |-> result.status == STAT_DONE)
    else $error("frame returned with a refusal status");

  a_no_busy_twice: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("execute lasted more than one cycle");

endmodule
